// ===== sv/fwpc_pkg.sv =====
// Shared constants and types for the FIFO-replacement word cache.
`default_nettype none
package fwpc_pkg;

  // Geometry
  localparam int ENTRIES   = 20;
  localparam int ADDR_BITS = 10;
  localparam int DATA_BITS = 16;
  localparam int MEM_WORDS = 1 << ADDR_BITS;
  localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_BITS = $clog2(ENTRIES + 1);

  // Configuration port
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WRITE_THROUGH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WRITE_ALLOCATE = 2'd1;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // One write beat toward the backing memory
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] data;
  } mem_wr_t;

endpackage
`default_nettype wire

// ===== sv/fwpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fwpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read at the address written in the same cycle sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/fifo_write_policy_cache_core.sv =====
// Top level: fully associative word cache with FIFO replacement and backing memory.
//
//  channel   ports                                          direction  handshake
//  input     in_operation, in_address, in_write_data        in         start & !busy
//  result    out_hit, out_read_data, out_evicted,           out        out_valid strobe
//            out_memory_written
//  config    cfg_index, cfg_wdata                           in         cfg_valid & cfg_ready
//
// After reset the backing memory is cleared one word a cycle: busy stays high while
// the sweep runs over all 2^ADDR_BITS words; config beats are taken meanwhile.
// One item per cycle while busy is low: the beat is registered in the item register,
// tags are compared in parallel, and the result strobe follows in the cycle after.
// A store miss that allocates over a dirty oldest slot needs two memory writes on the
// single RAM write port, so busy rises for one extra cycle after it.
// The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none
module fifo_write_policy_cache_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_operation,
  input  wire logic [fwpc_pkg::ADDR_BITS-1:0]        in_address,
  input  wire logic [fwpc_pkg::DATA_BITS-1:0]        in_write_data,
  // result channel
  output logic                                       out_valid,
  output logic                                       out_hit,
  output logic      [fwpc_pkg::DATA_BITS-1:0]        out_read_data,
  output logic                                       out_evicted,
  output logic                                       out_memory_written,
  // configuration channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [fwpc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic                                  cfg_wdata
);

  typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_WRITE2} state_t;

  state_t state_r;

  // config registers
  logic wt_r, wa_r;

  // memory clear sweep
  logic [fwpc_pkg::ADDR_BITS-1:0] clr_cnt_r;

  // item register
  logic                           q_valid_r;
  logic                           q_op_r;
  logic [fwpc_pkg::ADDR_BITS-1:0] q_addr_r;
  logic [fwpc_pkg::DATA_BITS-1:0] q_wdata_r;

  // slot storage
  logic [fwpc_pkg::ADDR_BITS-1:0] slot_tag_r   [fwpc_pkg::ENTRIES];
  logic [fwpc_pkg::DATA_BITS-1:0] slot_word_r  [fwpc_pkg::ENTRIES];
  logic [fwpc_pkg::ENTRIES-1:0]   slot_valid_r;
  logic [fwpc_pkg::ENTRIES-1:0]   slot_dirty_r;
  logic [fwpc_pkg::SLOT_BITS-1:0] oldest_r;
  logic [fwpc_pkg::FILL_BITS-1:0] fill_r;

  // deferred second write and last committed write (for forwarding)
  logic [fwpc_pkg::ADDR_BITS-1:0] pend_addr_r;
  logic [fwpc_pkg::DATA_BITS-1:0] pend_data_r;
  logic                           lw_valid_r;
  logic [fwpc_pkg::ADDR_BITS-1:0] lw_addr_r;
  logic [fwpc_pkg::DATA_BITS-1:0] lw_data_r;

  // result register
  logic                           out_valid_r;
  logic                           out_hit_r;
  logic [fwpc_pkg::DATA_BITS-1:0] out_read_data_r;
  logic                           out_evicted_r;
  logic                           out_mem_wr_r;

  // combinational
  logic                           accept;
  logic                           proc;
  logic                           is_store;
  logic [fwpc_pkg::ENTRIES-1:0]   match;
  logic                           hit;
  logic [fwpc_pkg::DATA_BITS-1:0] hit_word;
  logic                           full;
  logic [fwpc_pkg::SLOT_BITS-1:0] ins_idx;
  logic [fwpc_pkg::ADDR_BITS-1:0] vic_tag;
  logic [fwpc_pkg::DATA_BITS-1:0] vic_word;
  logic                           vic_dirty;
  logic [fwpc_pkg::DATA_BITS-1:0] ram_rdata;
  logic [fwpc_pkg::DATA_BITS-1:0] mem_data;
  logic                           do_insert;
  logic                           evict;
  logic                           wb;
  logic                           store_wr;
  logic                           need2;
  logic [fwpc_pkg::DATA_BITS-1:0] ins_word;
  logic [fwpc_pkg::DATA_BITS-1:0] rdata;
  fwpc_pkg::mem_wr_t              proc_wr;
  fwpc_pkg::mem_wr_t              ram_wr;
  logic [fwpc_pkg::ADDR_BITS-1:0] ram_raddr;

  // handshakes
  assign busy      = (state_r != ST_RUN);
  assign accept    = start && !busy;
  assign proc      = q_valid_r && (state_r == ST_RUN);
  assign cfg_ready = 1'b1;
  assign is_store  = (q_op_r == fwpc_pkg::OP_STORE);

  // parallel tag compare and one-hot reads of the hit and oldest slots
  always_comb begin
    hit_word  = '0;
    vic_tag   = '0;
    vic_word  = '0;
    vic_dirty = 1'b0;
    for (int i = 0; i < fwpc_pkg::ENTRIES; i++) begin
      match[i] = slot_valid_r[i] && (slot_tag_r[i] == q_addr_r);
      if (match[i]) begin
        hit_word = hit_word | slot_word_r[i];
      end
      if (oldest_r == fwpc_pkg::SLOT_BITS'(i)) begin
        vic_tag   = vic_tag | slot_tag_r[i];
        vic_word  = vic_word | slot_word_r[i];
        vic_dirty = vic_dirty | slot_dirty_r[i];
      end
    end
  end

  assign hit  = |match;
  assign full = (fill_r == fwpc_pkg::FILL_BITS'(fwpc_pkg::ENTRIES));
  // before the cache first fills, the oldest slot is slot zero
  assign ins_idx = full ? oldest_r : fill_r[fwpc_pkg::SLOT_BITS-1:0];

  // memory word, forwarding the write committed at the read edge
  assign mem_data = (lw_valid_r && (lw_addr_r == q_addr_r)) ? lw_data_r : ram_rdata;

  // policy decisions
  assign do_insert = proc && !hit && (!is_store || wa_r);
  assign evict     = do_insert && full;
  assign wb        = evict && vic_dirty;
  assign store_wr  = proc && is_store && (!hit || wt_r);
  assign need2     = wb && store_wr;
  assign ins_word  = is_store ? q_wdata_r : mem_data;
  assign rdata     = is_store ? '0 : (hit ? hit_word : mem_data);

  // write from this item: dirty write-back first, the store goes later if both
  always_comb begin
    proc_wr.en   = wb || store_wr;
    proc_wr.addr = wb ? vic_tag : q_addr_r;
    proc_wr.data = wb ? vic_word : q_wdata_r;
  end

  // RAM port selection
  always_comb begin
    case (state_r)
      ST_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = clr_cnt_r;
        ram_wr.data = '0;
      end
      ST_WRITE2: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = pend_addr_r;
        ram_wr.data = pend_data_r;
      end
      default: ram_wr = proc_wr;
    endcase
  end

  // re-read the held item while the second write goes out
  assign ram_raddr = (state_r == ST_WRITE2) ? q_addr_r : in_address;

  fwpc_ram #(
    .WIDTH (fwpc_pkg::DATA_BITS),
    .DEPTH (fwpc_pkg::MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // state, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      wt_r           <= 1'b1;
      wa_r           <= 1'b1;
      q_valid_r      <= 1'b0;
      oldest_r       <= '0;
      fill_r         <= '0;
      lw_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      out_hit_r      <= 1'b0;
      out_read_data_r <= '0;
      out_evicted_r  <= 1'b0;
      out_mem_wr_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + fwpc_pkg::ADDR_BITS'(1);
          if (clr_cnt_r == {fwpc_pkg::ADDR_BITS{1'b1}}) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (need2) begin
            state_r <= ST_WRITE2;
          end
        end
        ST_WRITE2: state_r <= ST_RUN;
        default:   state_r <= ST_CLEAR;
      endcase

      // config beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fwpc_pkg::REG_WRITE_THROUGH:  wt_r <= cfg_wdata;
          fwpc_pkg::REG_WRITE_ALLOCATE: wa_r <= cfg_wdata;
          default: ;
        endcase
      end

      // item register occupancy
      if (accept) begin
        q_valid_r <= 1'b1;
      end else if (proc) begin
        q_valid_r <= 1'b0;
      end

      // FIFO bookkeeping
      if (do_insert && !full) begin
        fill_r <= fill_r + fwpc_pkg::FILL_BITS'(1);
      end
      if (evict) begin
        oldest_r <= (oldest_r == fwpc_pkg::SLOT_BITS'(fwpc_pkg::ENTRIES - 1)) ?
                    '0 : oldest_r + fwpc_pkg::SLOT_BITS'(1);
      end

      lw_valid_r <= ram_wr.en;

      // result beat
      out_valid_r <= proc;
      if (proc) begin
        out_hit_r       <= hit;
        out_read_data_r <= rdata;
        out_evicted_r   <= evict;
        out_mem_wr_r    <= wb || store_wr;
      end
    end
  end

  // valid and dirty bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      slot_dirty_r <= '0;
    end else begin
      for (int i = 0; i < fwpc_pkg::ENTRIES; i++) begin
        if (do_insert && (ins_idx == fwpc_pkg::SLOT_BITS'(i))) begin
          slot_valid_r[i] <= 1'b1;
          slot_dirty_r[i] <= 1'b0;
        end else if (proc && is_store && match[i]) begin
          slot_dirty_r[i] <= !wt_r;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      q_op_r    <= in_operation;
      q_addr_r  <= in_address;
      q_wdata_r <= in_write_data;
    end
    if (need2) begin
      pend_addr_r <= q_addr_r;
      pend_data_r <= q_wdata_r;
    end
    lw_addr_r <= ram_wr.addr;
    lw_data_r <= ram_wr.data;
    for (int i = 0; i < fwpc_pkg::ENTRIES; i++) begin
      if (do_insert && (ins_idx == fwpc_pkg::SLOT_BITS'(i))) begin
        slot_tag_r[i]  <= q_addr_r;
        slot_word_r[i] <= ins_word;
      end else if (proc && is_store && match[i]) begin
        slot_word_r[i] <= q_wdata_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_read_data      = out_read_data_r;
  assign out_evicted        = out_evicted_r;
  assign out_memory_written = out_mem_wr_r;

  // checks
  a_write2_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE2) |=> (state_r == ST_RUN))
    else $error("second write state lasted more than one cycle");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(q_valid_r && (state_r == ST_RUN)))
    else $error("result strobe without a processed item");

  a_unique_tags: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("address present in more than one slot");

  a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evicted_r) |-> full)
    else $error("eviction reported while cache not full");

  a_oldest_moves_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_r != '0) |-> full)
    else $error("oldest pointer advanced before cache filled");

endmodule
`default_nettype wire
